// ===== design/sorted_priority_queue_remove_by_id_macros.svh =====
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_MACROS_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT(label, expr, msg)

`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/spq_pkg.sv =====
// types and codes shared by the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned KEY_W     = 20;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_POP_MIN   = 2'd1,
    OP_POP_MAX   = 2'd2,
    OP_REMOVE_ID = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   en;
    op_e    op;
    entry_t item;
  } cmd_t;

  typedef struct packed {
    entry_t item;
    logic   valid;
    logic   gt;
    logic   found;
  } link_t;

endpackage

`default_nettype wire

// ===== design/spq_in_if.sv =====
// input channel of the sorted priority queue
`default_nettype none

interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic [spq_pkg::ID_W-1:0]         entry_id;
  logic [spq_pkg::KEY_W-1:0]        entry_key;
  logic [spq_pkg::PAYLOAD_W-1:0]    entry_payload;

  modport source (output valid, op, entry_id, entry_key, entry_payload, input ready);
  modport sink   (input valid, op, entry_id, entry_key, entry_payload, output ready);
endinterface

`default_nettype wire

// ===== design/spq_out_if.sv =====
// result channel of the sorted priority queue
`default_nettype none

interface spq_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [spq_pkg::ID_W-1:0]         out_id;
  logic [spq_pkg::KEY_W-1:0]        out_key;
  logic [spq_pkg::PAYLOAD_W-1:0]    out_payload;
  logic [spq_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, status, out_id, out_key, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_key, out_payload, occupancy, output ready);
endinterface

`default_nettype wire

// ===== design/spq_cell.sv =====
// one slot of the sorted row, trades entries with its neighbors
`default_nettype none

module spq_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spq_pkg::cmd_t  cmd_i,
  input  wire spq_pkg::link_t prev_i,
  input  wire spq_pkg::link_t next_i,
  output spq_pkg::link_t      link_o,
  output logic                hit_o
);

  spq_pkg::entry_t item_q, item_d;
  logic            valid_q, valid_d;
  logic            gt;
  logic            match;
  logic            found;

  always_comb begin
    gt    = valid_q && (item_q.key > cmd_i.item.key);
    match = valid_q && (item_q.id == cmd_i.item.id);
    found = prev_i.found | match;
  end

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    hit_o   = 1'b0;
    if (cmd_i.en) begin
      case (cmd_i.op)
        spq_pkg::OP_INSERT: begin
          if (prev_i.gt) begin
            item_d = prev_i.item;
          end else if (gt || (!valid_q && prev_i.valid)) begin
            item_d = cmd_i.item;
          end
          valid_d = valid_q | prev_i.valid;
        end
        spq_pkg::OP_POP_MIN: begin
          item_d  = next_i.item;
          valid_d = next_i.valid;
        end
        spq_pkg::OP_POP_MAX: begin
          hit_o   = valid_q && !next_i.valid;
          valid_d = valid_q && next_i.valid;
        end
        spq_pkg::OP_REMOVE_ID: begin
          hit_o = match && !prev_i.found;
          if (found) begin
            item_d  = next_i.item;
            valid_d = next_i.valid;
          end
        end
        default: begin
          item_d = item_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign link_o = '{item: item_q, valid: valid_q, gt: gt, found: found};

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_remove_by_id.sv =====
// an input transfer loads the command register, and the cell row result is then registered into the output register
// the input is not ready while a command executes or an unaccepted result is held, so a new item waits for the last
// each operation but an insert into a full queue updates all cells in the cycle after the command register
// reset clears the cell valid bits, the entry count and the handshake state
// entry storage is not cleared; invalid cells are never read
`default_nettype none
`include "sorted_priority_queue_remove_by_id_macros.svh"

module sorted_priority_queue_remove_by_id #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_pkg::cmd_t   cmd_q;
  spq_pkg::cmd_t   cell_cmd;
  logic            exec_q;
  logic [CW-1:0]   count_q, count_d;
  spq_pkg::link_t  links [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] valid_vec;
  logic            full;
  logic            empty;

  spq_pkg::entry_t  res_item;
  spq_pkg::status_e res_status;

  logic                          out_valid_q;
  spq_pkg::status_e              status_q;
  spq_pkg::entry_t               res_q;
  logic [spq_pkg::OCC_W-1:0]     occ_q;

  localparam spq_pkg::link_t HEAD = '{item: '0, valid: 1'b1, gt: 1'b0, found: 1'b0};
  localparam spq_pkg::link_t TAIL = '{item: '0, valid: 1'b0, gt: 1'b0, found: 1'b0};

  assign in_i.ready = !exec_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q.en           <= 1'b1;
      cmd_q.op           <= spq_pkg::op_e'(in_i.op);
      cmd_q.item.id      <= in_i.entry_id;
      cmd_q.item.key     <= in_i.entry_key;
      cmd_q.item.payload <= in_i.entry_payload;
    end
  end

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    cell_cmd    = cmd_q;
    cell_cmd.en = exec_q && !((cmd_q.op == spq_pkg::OP_INSERT) && full);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::link_t prev_link;
    spq_pkg::link_t next_link;
    if (i == 0) begin : g_head
      assign prev_link = HEAD;
    end else begin : g_mid
      assign prev_link = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_link = TAIL;
    end else begin : g_body
      assign next_link = links[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cell_cmd),
      .prev_i (prev_link),
      .next_i (next_link),
      .link_o (links[i]),
      .hit_o  (hits[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // result entry, status and next entry count
  always_comb begin
    res_item   = '0;
    res_status = spq_pkg::ST_OK;
    count_d    = count_q;
    for (int i = 0; i < DEPTH; i++) begin
      res_item = res_item | ({$bits(spq_pkg::entry_t){hits[i]}} & links[i].item);
    end
    case (cmd_q.op)
      spq_pkg::OP_INSERT: begin
        res_item = '0;
        if (full) begin
          res_status = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::OP_POP_MIN: begin
        res_item = links[0].valid ? links[0].item : '0;
        if (empty) begin
          res_status = spq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      spq_pkg::OP_POP_MAX: begin
        if (empty) begin
          res_status = spq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      spq_pkg::OP_REMOVE_ID: begin
        if (links[DEPTH-1].found) begin
          count_d = count_q - CW'(1);
        end else begin
          res_status = spq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      exec_q <= in_i.valid && in_i.ready;
      if (exec_q) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_q) begin
      status_q <= res_status;
      res_q    <= res_item;
      occ_q    <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.out_id      = res_q.id;
  assign out_o.out_key     = res_q.key;
  assign out_o.out_payload = res_q.payload;
  assign out_o.occupancy   = occ_q;

  `SPQ_ASSERT(a_count_matches_cells, $countones(valid_vec) == int'(count_q), "count mismatch")
  `SPQ_ASSERT(a_cells_packed, ((({1'b0, valid_vec}) + 1'b1) & {1'b0, valid_vec}) == '0, "gap in row")
  `SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_exec_gives_result, exec_q, out_valid_q, "result not registered")
  `SPQ_ASSERT_NEXT(a_one_in_flight, exec_q, !exec_q, "back to back execute")

endmodule

`default_nettype wire

// ===== tb/sv/spq_result_checker.sv =====
// result checker for the sorted priority queue: predicts each transfer and compares results
`timescale 1ns / 100ps

module spq_result_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_in_if           in_mon_i,
  spq_out_if          out_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e                status;
    logic [ID_W-1:0]        id;
    logic [KEY_W-1:0]       key;
    logic [PAYLOAD_W-1:0]   payload;
    logic [OCC_W-1:0]       occupancy;
  } queue_result_t;

  entry_t        held [DEPTH];
  int unsigned   held_count;
  queue_result_t expected_results [$];
  queue_result_t want;
  entry_t        arriving;
  int unsigned   fails;

  // one operation on the shadow queue, returning the result it must give
  function automatic queue_result_t predict_queue_op(op_e op, entry_t item);
    queue_result_t res;
    int unsigned   pos;
    int unsigned   i;
    bit            hit;
    res        = '0;
    res.status = ST_OK;
    pos        = 0;
    hit        = 1'b0;
    case (op)
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // equal keys stay ahead of the new entry
          pos = held_count;
          while (pos > 0 && held[pos-1].key > item.key) begin
            held[pos] = held[pos-1];
            pos--;
          end
          held[pos] = item;
          held_count++;
        end
      end
      OP_POP_MIN, OP_POP_MAX: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = (op == OP_POP_MIN) ? 0 : held_count - 1;
          hit = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < held_count && !hit; i++) begin
          if (held[i].id == item.id) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
    endcase
    if (hit) begin
      res.id      = held[pos].id;
      res.key     = held[pos].key;
      res.payload = held[pos].payload;
      for (i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
      held_count--;
    end
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic int unsigned field_check(string name, logic [31:0] exp_val,
                                              logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      fails = 0;
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none actual status %0d id 0x%0h",
                   $time, out_mon_i.status, out_mon_i.out_id);
          fails++;
        end else begin
          want  = expected_results.pop_front();
          fails += field_check("status", want.status, out_mon_i.status);
          fails += field_check("out_id", want.id, out_mon_i.out_id);
          fails += field_check("out_key", want.key, out_mon_i.out_key);
          fails += field_check("out_payload", want.payload, out_mon_i.out_payload);
          fails += field_check("occupancy", want.occupancy, out_mon_i.occupancy);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        arriving.id      = in_mon_i.entry_id;
        arriving.key     = in_mon_i.entry_key;
        arriving.payload = in_mon_i.entry_payload;
        expected_results.push_back(predict_queue_op(op_e'(in_mon_i.op), arriving));
      end
      mismatch_count_o <= mismatch_count_o + fails;
      pending_o        <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_sorted_priority_queue_remove_by_id.sv =====
// testbench top for the sorted priority queue: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_sorted_priority_queue_remove_by_id;
  import spq_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned PHASES          = 14;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_pct      = 12;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned op_tally [4]  = '{default: 0};
  int unsigned cycle_count;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_remove_by_id #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  spq_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_ch),
    .out_mon_i        (out_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  initial begin : result_sink
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done < hold_requests) begin
        out_ch.ready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk_i);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic offer_item(input op_e op, input logic [ID_W-1:0] id,
                            input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] payload);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.entry_id      <= id;
    in_ch.entry_key     <= key;
    in_ch.entry_payload <= payload;
    do @(posedge clk_i); while (!in_ch.ready);
    op_tally[op]++;
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      k;
    int unsigned      pick;
    op_e              op;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;

    in_ch.valid         = 1'b0;
    in_ch.op            = OP_INSERT;
    in_ch.entry_id      = '0;
    in_ch.entry_key     = '0;
    in_ch.entry_payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue cases
    offer_item(OP_POP_MIN, 16'h0001, '0, '0);
    offer_item(OP_POP_MAX, 16'h0002, '0, '0);
    offer_item(OP_REMOVE_ID, 16'h0003, '0, '0);
    // field extremes, equal keys and a repeated id
    offer_item(OP_INSERT, 16'h0000, 20'h00000, 32'h0000_0000);
    offer_item(OP_INSERT, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    offer_item(OP_INSERT, 16'h0007, 20'h00005, 32'h0000_000A);
    offer_item(OP_INSERT, 16'h0008, 20'h00005, 32'h0000_000B);
    offer_item(OP_INSERT, 16'h0007, 20'h00005, 32'h0000_000C);
    for (k = 0; k < 11; k++) begin
      offer_item(OP_INSERT, 16'(100 + k), 20'((k * 37) % 11), $urandom());
    end
    // full queue drops the insert
    offer_item(OP_INSERT, 16'h5555, 20'hAAAAA, 32'h5A5A_A5A5);
    offer_item(OP_REMOVE_ID, 16'h0007, '0, '0);
    offer_item(OP_REMOVE_ID, 16'h1234, '0, '0);
    offer_item(OP_POP_MAX, '0, '0, '0);
    offer_item(OP_POP_MIN, '0, '0, '0);
    wait_until_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      idle_pct <= (phase == 5 || phase == 6) ? 0 : 12;
      if (phase == 3 || phase == 10) hold_requests <= hold_requests + 1;
      if (phase == 9) wait_until_drained();
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(99);
        case (phase % 3)
          0: op = (pick < 65) ? OP_INSERT : (pick < 77) ? OP_POP_MIN :
                  (pick < 87) ? OP_POP_MAX : OP_REMOVE_ID;
          1: op = (pick < 45) ? OP_INSERT : (pick < 60) ? OP_POP_MIN :
                  (pick < 75) ? OP_POP_MAX : OP_REMOVE_ID;
          default: op = (pick < 25) ? OP_INSERT : (pick < 45) ? OP_POP_MIN :
                        (pick < 65) ? OP_POP_MAX : OP_REMOVE_ID;
        endcase
        // small id pool so removes often hit, with full-range ids now and then
        id = ($urandom_range(7) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(15));
        case ($urandom_range(3))
          0:       key = KEY_W'($urandom());
          1:       key = KEY_W'($urandom_range(7));
          default: key = KEY_W'($urandom_range(1000));
        endcase
        offer_item(op, id, key, $urandom());
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d inserts, %0d smallest-key pops, %0d largest-key pops, %0d id removals",
             op_tally[OP_INSERT], op_tally[OP_POP_MIN], op_tally[OP_POP_MAX],
             op_tally[OP_REMOVE_ID]);
    $display("including full, empty and missing-id cases, %0d mismatches", mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
